// ===== hw/rtl/tsse_pkg.sv =====
// ----------------------------------------------------------------------------
// tsse_pkg
// shared types, character constants and hex digit helper for the slug encoder
// ----------------------------------------------------------------------------
package tsse_pkg;

  localparam int unsigned SlotCount = 4;

  localparam logic [7:0] CharHyphen     = 8'h2D;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharPercent    = 8'h25;
  localparam logic [7:0] CaseOffset     = 8'h20;
  localparam logic [7:0] HighAscii      = 8'h7F;

  typedef logic [$clog2(SlotCount)-1:0] slot_idx_t;

  // up to four result bytes caused by one request
  typedef struct packed {
    logic                      keep;
    logic [SlotCount-1:0][7:0] slots;
    slot_idx_t                 last_idx;
    logic                      data_valid;
    logic                      end_of_slug;
  } bundle_t;

  typedef struct packed {
    logic text_seen;
    logic hyphen_pending;
  } slug_state_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tsse_classify.sv =====
// ----------------------------------------------------------------------------
// tsse_classify
// maps one source byte and the slug state to a result bundle and next state
// ----------------------------------------------------------------------------
module tsse_classify
  import tsse_pkg::*;
(
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  input  slug_state_t state_cur,
  output bundle_t     bundle,
  output slug_state_t state_next
);

  logic [7:0]                folded;
  logic                      is_hyphen;
  logic                      is_alnum;
  logic                      is_high;
  logic                      has_out;
  logic [SlotCount-1:0][7:0] body;
  slot_idx_t                 body_last;

  always_comb begin
    folded = in_byte;
    if (in_byte inside {[8'h41:8'h5A]}) begin
      folded = in_byte + CaseOffset;
    end
    is_hyphen = (folded == CharHyphen) || (folded == CharSpace) ||
                (folded == CharUnderscore);
    is_alnum  = folded inside {[8'h61:8'h7A], [8'h30:8'h39]};
    is_high   = (in_byte > HighAscii);
    has_out   = is_alnum || is_high;

    body      = '0;
    body_last = '0;
    if (is_high) begin
      body[0]   = CharPercent;
      body[1]   = hex_digit(in_byte[7:4]);
      body[2]   = hex_digit(in_byte[3:0]);
      body_last = slot_idx_t'(2);
    end else begin
      body[0]   = folded;
    end

    bundle             = '0;
    bundle.keep        = has_out || last_byte;
    bundle.end_of_slug = last_byte;
    bundle.data_valid  = has_out;
    if (has_out) begin
      if (state_cur.hyphen_pending) begin
        bundle.slots    = {body[SlotCount-2:0], CharHyphen};
        bundle.last_idx = body_last + slot_idx_t'(1);
      end else begin
        bundle.slots    = body;
        bundle.last_idx = body_last;
      end
    end

    state_next = state_cur;
    if (is_hyphen) begin
      if (state_cur.text_seen) begin
        state_next.hyphen_pending = 1'b1;
      end
    end else if (has_out) begin
      state_next.hyphen_pending = 1'b0;
      state_next.text_seen      = 1'b1;
    end
    if (last_byte) begin
      state_next = '0;
    end
  end

endmodule

// ===== hw/rtl/text_slug_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// text_slug_stream_encoder
// streaming url slug encoder, one source byte per request, 0 to 4 slug bytes
// ----------------------------------------------------------------------------
// latency: first result is offered the cycle after the source request
// throughput: one request per cycle while each gives at most one result and slug_stall is low;
//   a request giving n results holds the bundle register until all n are taken (n <= 4)
// the bundle register is the only buffer between the two channels
// reset clears the slug state and empties the bundle register
// ----------------------------------------------------------------------------
module text_slug_stream_encoder
  import tsse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       slug_valid,
  input  logic       slug_stall,
  output logic [7:0] out_byte,
  output logic       data_valid,
  output logic       end_of_slug
);

  slug_state_t state;
  slug_state_t state_next;
  bundle_t     bundle;
  bundle_t     bundle_next;
  logic        busy;
  slot_idx_t   idx;
  logic        src_fire;
  logic        slug_fire;
  logic        at_final;

  tsse_classify u_classify (
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .state_cur  (state),
    .bundle     (bundle_next),
    .state_next (state_next)
  );

  assign at_final    = (idx == bundle.last_idx);
  assign slug_valid  = busy;
  assign slug_fire   = busy && !slug_stall;
  assign src_stall   = busy && !(slug_fire && at_final);
  assign src_fire    = src_valid && !src_stall;
  assign out_byte    = bundle.slots[idx];
  assign data_valid  = bundle.data_valid;
  assign end_of_slug = bundle.end_of_slug && at_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      busy  <= 1'b0;
      idx   <= '0;
    end else begin
      if (src_fire) begin
        state <= state_next;
      end
      if (src_fire && bundle_next.keep) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (slug_fire) begin
        if (at_final) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + slot_idx_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire && bundle_next.keep) begin
      bundle <= bundle_next;
    end
  end

  // a held hyphen only exists after some text
  a_pending_needs_text: assert property (@(posedge clk) disable iff (rst)
    state.hyphen_pending |-> state.text_seen)
    else $error("hyphen pending without text seen");

  // read pointer never runs past the bundle
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= bundle.last_idx))
    else $error("slot index beyond bundle");

  // a bare marker is always the end of a slug
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (busy && !data_valid) |-> (end_of_slug && bundle.last_idx == '0))
    else $error("bare result without end flag");

  // taking a non-final slot keeps the bundle and advances the pointer
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (slug_fire && !at_final) |=> (busy && idx == $past(idx) + slot_idx_t'(1)))
    else $error("bundle slot skipped or dropped");

  // end of slug clears the state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (src_fire && last_byte) |=> (state == '0))
    else $error("state not cleared at end of slug");

endmodule
